### rtl/oaht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_pkg: shared types and codes for the open-addressing hash table
// Request types, status codes, slot use marks and controller/datapath links.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUP      = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] USE_FREE = 2'd0;
  localparam logic [1:0] USE_OCC  = 2'd1;
  localparam logic [1:0] USE_REM  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;   // write one use mark during the clearing pass
    logic load;         // latch request, set home slot
    logic advance;      // move to next probe slot
    logic note_tomb;    // record current slot as first tombstone
    logic wr_ins;       // write key/value/occupied at current slot
    logic wr_rem;       // mark current slot removed
    logic wr_move;      // copy current entry into tombstone slot
    logic cnt_inc;
    logic cnt_dec;
    logic done;         // present result
    logic [1:0] status;
    logic use_found;    // found_value from slot read
  } oaht_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] use_mark;
    logic       key_hit;
    logic       tomb_seen;
    logic       last_probe;
    logic       clear_last;
  } oaht_sts_t;

endpackage

### rtl/oaht_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_ram: generic single-port RAM
// One write or read a cycle, registered read data.
// ----------------------------------------------------------------------------
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/oaht_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_datapath: slot memories, probe index and result registers
// Holds the request, walks the triangular probe sequence and owns the count.
// ----------------------------------------------------------------------------
module oaht_datapath #(
  parameter int MAX_SLOTS  = 1024,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_data,
  input  logic [1:0]           req_type,
  input  logic [63:0]          key,
  input  logic [31:0]          key_hash,
  input  logic [31:0]          value,
  input  oaht_pkg::oaht_cmd_t  cmd,
  output oaht_pkg::oaht_sts_t  sts,
  output logic                 done,
  output logic [1:0]           status,
  output logic [31:0]          found_value,
  output logic [10:0]          entry_total
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int LW = $clog2(AW + 1);
  localparam int CW = AW + 1;

  logic [3:0]            capacity_log2;
  logic [LW-1:0]         lg;
  logic [AW-1:0]         mask;
  logic [1:0]            rtype;
  logic [KEY_BITS-1:0]   rkey;
  logic [VALUE_BITS-1:0] rval;
  logic [AW-1:0]         idx;
  logic [AW-1:0]         step;
  logic [CW-1:0]         probe_n;
  logic [AW-1:0]         tomb;
  logic                  tomb_seen;
  logic [CW-1:0]         occupied_count;
  logic [AW-1:0]         addr;
  logic                  use_we, kv_we;
  logic [1:0]            use_wd, use_rd;
  logic [KEY_BITS-1:0]   key_wd, key_rd;
  logic [VALUE_BITS-1:0] val_wd, val_rd;
  logic [CW-1:0]         cap;

  always_comb begin
    if (capacity_log2 < 4'd1) begin
      lg = LW'(1);
    end else if (32'(capacity_log2) > AW) begin
      lg = LW'(AW);
    end else begin
      lg = LW'(capacity_log2);
    end
    cap  = CW'(1) << lg;
    mask = AW'(cap - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_log2 <= 4'd5;
    end else if (cfg_we) begin
      capacity_log2 <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rtype <= req_type;
      rkey  <= key[KEY_BITS-1:0];
      rval  <= value[VALUE_BITS-1:0];
    end
  end

  // probe index doubles as the clearing-pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      step      <= '0;
      probe_n   <= '0;
      tomb_seen <= 1'b0;
      tomb      <= '0;
    end else if (cmd.clear_step) begin
      idx <= idx + AW'(1);
    end else if (cmd.load) begin
      idx       <= key_hash[AW-1:0] & mask;
      step      <= AW'(1);
      probe_n   <= CW'(1);
      tomb_seen <= 1'b0;
    end else begin
      if (cmd.advance) begin
        idx     <= (idx + step) & mask;
        step    <= step + AW'(1);
        probe_n <= probe_n + CW'(1);
      end
      if (cmd.note_tomb) begin
        tomb_seen <= 1'b1;
        tomb      <= idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied_count <= '0;
    end else if (cmd.cnt_inc) begin
      occupied_count <= occupied_count + CW'(1);
    end else if (cmd.cnt_dec && occupied_count != '0) begin
      occupied_count <= occupied_count - CW'(1);
    end
  end

  always_comb begin
    addr   = idx;
    use_we = 1'b0;
    kv_we  = 1'b0;
    use_wd = oaht_pkg::USE_FREE;
    key_wd = rkey;
    val_wd = rval;
    if (cmd.clear_step) begin
      use_we = 1'b1;
    end else if (cmd.wr_ins) begin
      use_we = 1'b1;
      kv_we  = 1'b1;
      use_wd = oaht_pkg::USE_OCC;
    end else if (cmd.wr_rem) begin
      use_we = 1'b1;
      use_wd = oaht_pkg::USE_REM;
    end else if (cmd.wr_move) begin
      addr   = tomb;
      use_we = 1'b1;
      kv_we  = 1'b1;
      use_wd = oaht_pkg::USE_OCC;
      key_wd = key_rd;
      val_wd = val_rd;
    end
  end

  oaht_ram #(.WIDTH(2), .DEPTH(MAX_SLOTS)) u_use (
    .clk(clk), .we(use_we), .addr(addr), .wdata(use_wd), .rdata(use_rd));
  oaht_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_SLOTS)) u_key (
    .clk(clk), .we(kv_we), .addr(addr), .wdata(key_wd), .rdata(key_rd));
  oaht_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_SLOTS)) u_val (
    .clk(clk), .we(kv_we), .addr(addr), .wdata(val_wd), .rdata(val_rd));

  always_comb begin
    sts.req_type   = rtype;
    sts.use_mark   = use_rd;
    sts.key_hit    = (key_rd == rkey);
    sts.tomb_seen  = tomb_seen;
    sts.last_probe = (probe_n >= cap);
    sts.clear_last = (idx == AW'(MAX_SLOTS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      status      <= cmd.status;
      found_value <= cmd.use_found ? 32'(val_rd) : 32'd0;
    end
  end

  assign entry_total = 11'(occupied_count);

endmodule

### rtl/oaht_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_ctrl: request sequencer
// Clears the use marks after reset, then runs one probe per read/check pair.
// ----------------------------------------------------------------------------
module oaht_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  oaht_pkg::oaht_sts_t sts,
  output oaht_pkg::oaht_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_CHECK = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = S_READ;
        if (sts.req_type == oaht_pkg::REQ_INSERT) begin
          if (sts.use_mark != oaht_pkg::USE_OCC) begin
            cmd.wr_ins  = 1'b1;
            cmd.cnt_inc = 1'b1;
            cmd.done    = 1'b1;
            cmd.status  = oaht_pkg::ST_OK;
            state_next  = S_IDLE;
          end else if (sts.key_hit) begin
            cmd.done   = 1'b1;
            cmd.status = oaht_pkg::ST_DUP;
            state_next = S_IDLE;
          end else if (sts.last_probe) begin
            cmd.done   = 1'b1;
            cmd.status = oaht_pkg::ST_FULL;
            state_next = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end else if (sts.req_type == oaht_pkg::REQ_SEARCH ||
                     sts.req_type == oaht_pkg::REQ_REMOVE) begin
          if (sts.use_mark == oaht_pkg::USE_FREE) begin
            cmd.done   = 1'b1;
            cmd.status = oaht_pkg::ST_NOT_FOUND;
            state_next = S_IDLE;
          end else if (sts.use_mark == oaht_pkg::USE_OCC && sts.key_hit) begin
            cmd.done      = 1'b1;
            cmd.status    = oaht_pkg::ST_OK;
            cmd.use_found = 1'b1;
            if (sts.req_type == oaht_pkg::REQ_REMOVE) begin
              cmd.wr_rem  = 1'b1;
              cmd.cnt_dec = 1'b1;
              state_next  = S_IDLE;
            end else if (sts.tomb_seen) begin
              // copy entry into the tombstone, then retire the old slot
              cmd.wr_move = 1'b1;
              state_next  = S_FIN;
            end else begin
              state_next = S_IDLE;
            end
          end else if (sts.last_probe) begin
            cmd.done   = 1'b1;
            cmd.status = oaht_pkg::ST_NOT_FOUND;
            state_next = S_IDLE;
          end else begin
            if (sts.use_mark != oaht_pkg::USE_OCC && !sts.tomb_seen) begin
              cmd.note_tomb = 1'b1;
            end
            cmd.advance = 1'b1;
          end
        end else begin
          cmd.done   = 1'b1;
          cmd.status = oaht_pkg::ST_NOT_FOUND;
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        cmd.wr_rem = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/open_addressing_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table: hash table with triangular probing
// Insert, search and remove of key/value entries in on-chip slot memories.
// ----------------------------------------------------------------------------
// Usage: drive req_type, key, key_hash and value and raise start while busy
// is low; the item is taken at that edge. One result per item appears on
// status, found_value and entry_total for one cycle with done high; it cannot
// be held off. Each probe is a registered slot read followed by a check.
// busy is low again in the cycle in which done is high, so the next item can
// be taken then; a search that moves its entry into an earlier tombstone
// holds busy high through a further state that retires the old slot.
// capacity_log2 is written through cfg_we / cfg_data; the user must do so
// only while idle, as the block itself does not enforce it. After reset the
// block runs a clearing pass over all MAX_SLOTS use marks with busy high.
// ----------------------------------------------------------------------------
module open_addressing_hash_table #(
  parameter int MAX_SLOTS  = 1024,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [63:0] key,
  input  logic [31:0] key_hash,
  input  logic [31:0] value,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] found_value,
  output logic [10:0] entry_total
);

  oaht_pkg::oaht_cmd_t cmd;
  oaht_pkg::oaht_sts_t sts;

  oaht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sts(sts), .cmd(cmd));

  oaht_datapath #(
    .MAX_SLOTS(MAX_SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req_type(req_type), .key(key), .key_hash(key_hash), .value(value),
    .cmd(cmd), .sts(sts), .done(done), .status(status),
    .found_value(found_value), .entry_total(entry_total));

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: open_addressing_hash_table
// Drives a short table of directed requests and then random phases of
// insert/search/remove traffic over small key pools at several capacities.
// Each result is checked against a typed row result or a testbench table model.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] REQ_NOP = 2'd3;
  localparam int SLOTS = 1024;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found;
    logic [10:0] total;
  } result_t;

  typedef struct {
    bit          is_cfg;
    logic [3:0]  cfg_val;
    logic [1:0]  req;
    logic [63:0] k;
    logic [31:0] h;
    logic [31:0] v;
    bit          typed;
    result_t     res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type = '0;
  logic [63:0] key = '0;
  logic [31:0] key_hash = '0;
  logic [31:0] value = '0;
  logic done;
  logic [1:0] status;
  logic [31:0] found_value;
  logic [10:0] entry_total;

  open_addressing_hash_table dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .busy(busy), .req_type(req_type), .key(key),
    .key_hash(key_hash), .value(value), .done(done), .status(status),
    .found_value(found_value), .entry_total(entry_total)
  );

  always #1 clk = ~clk;

  // table state as the block should hold it
  logic [1:0]  tbl_use [SLOTS];
  logic [63:0] tbl_key [SLOTS];
  logic [31:0] tbl_val [SLOTS];
  int unsigned tbl_count;
  logic [3:0]  cap_reg;

  result_t pending_q[$];
  int errors = 0;
  bit burst_mode = 0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int unsigned cur_capacity();
    int unsigned lg;
    lg = 32'(cap_reg);
    if (lg < 1) lg = 1;
    while (lg > 1 && (1 << lg) > SLOTS) lg--;
    return 1 << lg;
  endfunction

  task automatic table_apply(input logic [1:0] req, input logic [63:0] k,
                             input logic [31:0] h, input logic [31:0] v,
                             output result_t r);
    int unsigned cap, msk, i, stp, n, tomb;
    bit tomb_seen;
    cap = cur_capacity();
    msk = cap - 1;
    i = h & msk;
    stp = 1;
    tomb_seen = 0;
    tomb = 0;
    r.status = oaht_pkg::ST_NOT_FOUND;
    r.found = '0;
    if (req == oaht_pkg::REQ_INSERT) begin
      r.status = oaht_pkg::ST_FULL;
      for (n = 0; n < cap; n++) begin
        if (tbl_use[i] != oaht_pkg::USE_OCC) begin
          tbl_use[i] = oaht_pkg::USE_OCC;
          tbl_key[i] = k;
          tbl_val[i] = v;
          tbl_count++;
          r.status = oaht_pkg::ST_OK;
          break;
        end
        if (tbl_key[i] == k) begin
          r.status = oaht_pkg::ST_DUP;
          break;
        end
        i = (i + stp) & msk;
        stp++;
      end
    end else if (req == oaht_pkg::REQ_SEARCH || req == oaht_pkg::REQ_REMOVE) begin
      for (n = 0; n < cap; n++) begin
        if (tbl_use[i] == oaht_pkg::USE_FREE) break;
        if (tbl_use[i] == oaht_pkg::USE_OCC) begin
          if (tbl_key[i] == k) begin
            r.found = tbl_val[i];
            r.status = oaht_pkg::ST_OK;
            if (req == oaht_pkg::REQ_REMOVE) begin
              tbl_use[i] = oaht_pkg::USE_REM;
              if (tbl_count > 0) tbl_count--;
            end else if (tomb_seen) begin
              // move the entry forward into the first tombstone passed
              tbl_use[tomb] = oaht_pkg::USE_OCC;
              tbl_key[tomb] = tbl_key[i];
              tbl_val[tomb] = tbl_val[i];
              tbl_use[i] = oaht_pkg::USE_REM;
            end
            break;
          end
        end else if (!tomb_seen) begin
          tomb_seen = 1;
          tomb = i;
        end
        i = (i + stp) & msk;
        stp++;
      end
    end
    r.total = tbl_count[10:0];
  endtask

  task automatic send_item(input logic [1:0] req, input logic [63:0] k,
                           input logic [31:0] h, input logic [31:0] v,
                           input bit typed, input result_t typed_res);
    result_t r;
    int gap;
    req_type <= req;
    key <= k;
    key_hash <= h;
    value <= v;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    table_apply(req, k, h, v, r);
    pending_q.push_back(typed ? typed_res : r);
    gap = burst_mode ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_capacity(input logic [3:0] lg);
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0 || busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= lg;
    @(posedge clk);
    cap_reg = lg;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // results cannot be held off: take each one on the edge that ends it
  always @(posedge clk) begin
    result_t e;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        report("result with no item outstanding");
      end else begin
        e = pending_q.pop_front();
        if (status !== e.status)
          report($sformatf("status %0d, want %0d", status, e.status));
        if (found_value !== e.found)
          report($sformatf("found_value %h, want %h", found_value, e.found));
        if (entry_total !== e.total)
          report($sformatf("entry_total %0d, want %0d", entry_total, e.total));
      end
    end
  end

  initial begin
    #100000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    row_t dir[$];
    row_t rw;
    logic [63:0] pool_key [40];
    logic [31:0] pool_hash [40];
    logic [3:0] phase_caps [12];
    int pool_n, per_phase, p, j, sel, pick;
    logic [1:0] rq;
    logic [63:0] k;
    logic [31:0] h;
    result_t none;

    none = '0;
    for (int s = 0; s < SLOTS; s++) begin
      tbl_use[s] = oaht_pkg::USE_FREE;
      tbl_key[s] = '0;
      tbl_val[s] = '0;
    end
    tbl_count = 0;
    cap_reg = 4'd5;

    // directed rows; typed results only where obvious
    dir = '{
      '{0, 0, oaht_pkg::REQ_SEARCH, 64'd0, 32'd0, 32'd0, 1,
        '{oaht_pkg::ST_NOT_FOUND, 32'd0, 11'd0}},
      '{0, 0, oaht_pkg::REQ_REMOVE, 64'd0, 32'd0, 32'd0, 1,
        '{oaht_pkg::ST_NOT_FOUND, 32'd0, 11'd0}},
      '{0, 0, oaht_pkg::REQ_INSERT, 64'd0, 32'd0, '1, 1,
        '{oaht_pkg::ST_OK, 32'd0, 11'd1}},
      '{0, 0, oaht_pkg::REQ_INSERT, 64'd0, 32'd0, 32'd9, 1,
        '{oaht_pkg::ST_DUP, 32'd0, 11'd1}},
      '{0, 0, oaht_pkg::REQ_SEARCH, 64'd0, 32'd0, 32'd0, 1,
        '{oaht_pkg::ST_OK, '1, 11'd1}},
      '{0, 0, oaht_pkg::REQ_INSERT, '1, '1, 32'd0, 1,
        '{oaht_pkg::ST_OK, 32'd0, 11'd2}},
      '{0, 0, oaht_pkg::REQ_SEARCH, '1, '1, '1, 1,
        '{oaht_pkg::ST_OK, 32'd0, 11'd2}},
      '{0, 0, REQ_NOP, '1, '1, '1, 1,
        '{oaht_pkg::ST_NOT_FOUND, 32'd0, 11'd2}},
      '{0, 0, oaht_pkg::REQ_REMOVE, 64'd0, 32'd0, 32'd0, 1,
        '{oaht_pkg::ST_OK, '1, 11'd1}},
      '{0, 0, oaht_pkg::REQ_SEARCH, 64'd0, 32'd0, 32'd0, 1,
        '{oaht_pkg::ST_NOT_FOUND, 32'd0, 11'd1}},
      '{0, 0, oaht_pkg::REQ_INSERT, 64'd5, 32'd0, 32'h5555_aaaa, 1,
        '{oaht_pkg::ST_OK, 32'd0, 11'd2}},
      '{0, 0, oaht_pkg::REQ_INSERT, 64'd7, 32'h20, 32'haaaa_5555, 0, '0},
      '{0, 0, oaht_pkg::REQ_REMOVE, 64'd5, 32'd0, 32'd0, 0, '0},
      '{0, 0, oaht_pkg::REQ_SEARCH, 64'd7, 32'h40, 32'd0, 0, '0},
      '{0, 0, oaht_pkg::REQ_SEARCH, 64'd7, 32'd0, 32'd0, 0, '0},
      '{1, 4'd0, oaht_pkg::REQ_INSERT, 64'd0, 32'd0, 32'd0, 0, '0},
      '{0, 0, oaht_pkg::REQ_INSERT, 64'd100, 32'd0, 32'd1, 0, '0},
      '{0, 0, oaht_pkg::REQ_INSERT, 64'd101, 32'd1, 32'd2, 0, '0},
      '{0, 0, oaht_pkg::REQ_INSERT, 64'd102, 32'd0, 32'd3, 0, '0},
      '{0, 0, oaht_pkg::REQ_REMOVE, 64'd103, 32'd1, 32'd0, 0, '0},
      '{1, 4'd15, oaht_pkg::REQ_INSERT, 64'd0, 32'd0, 32'd0, 0, '0},
      '{0, 0, oaht_pkg::REQ_INSERT, 64'h8000_0000_0000_0001, 32'h8000_03ff,
        32'd4, 0, '0},
      '{0, 0, oaht_pkg::REQ_SEARCH, 64'h8000_0000_0000_0001, 32'h3ff,
        32'd0, 0, '0},
      '{0, 0, oaht_pkg::REQ_SEARCH, 64'd7, 32'd0, 32'd0, 0, '0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // hold off until the clearing pass is over
    while (busy) @(posedge clk);

    foreach (dir[i]) begin
      rw = dir[i];
      if (rw.is_cfg) write_capacity(rw.cfg_val);
      else send_item(rw.req, rw.k, rw.h, rw.v, rw.typed, rw.res);
    end

    phase_caps = '{4'd1, 4'd3, 4'd2, 4'd10, 4'd4, 4'd0, 4'd6, 4'd15,
                   4'd5, 4'd2, 4'd7, 4'd3};
    per_phase = 128;
    for (p = 0; p < 12; p++) begin
      write_capacity(phase_caps[p]);
      burst_mode = ($urandom_range(0, 3) == 0);
      pool_n = $urandom_range(2, 40);
      for (j = 0; j < pool_n; j++) begin
        pool_key[j] = {$urandom, $urandom};
        // crowd the home slots on some phases to force long probe chains
        pool_hash[j] = (p % 2) ? ($urandom & 32'h0000_0003) | ($urandom & 32'hffff_0000)
                               : $urandom;
      end
      for (j = 0; j < per_phase; j++) begin
        sel = $urandom_range(0, 99);
        pick = $urandom_range(0, pool_n - 1);
        k = pool_key[pick];
        h = pool_hash[pick];
        if (sel < 45) rq = oaht_pkg::REQ_INSERT;
        else if (sel < 72) rq = oaht_pkg::REQ_SEARCH;
        else if (sel < 92) rq = oaht_pkg::REQ_REMOVE;
        else begin
          // noise: random type, key and hash
          rq = 2'($urandom_range(0, 3));
          k = {$urandom, $urandom};
          h = $urandom;
        end
        send_item(rq, k, h, $urandom, 0, none);
        if (j % 40 == 39) burst_mode = ($urandom_range(0, 3) == 0);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
